// ===== src/padsr_pkg.sv =====
// padsr_pkg: shared types, codes and constants of the ADSR envelope bank.
// Depends on nothing; used by padsr_div and the top level.
`default_nettype none
package padsr_pkg;

  localparam int NUM_SLOTS_DEF      = 8;
  localparam int SAMPLES_PER_MS_DEF = 48;

  localparam int LVL_W = 16;   // Q0.16 level
  localparam int CNT_W = 24;   // phase count and sample spans
  localparam int NUM_W = LVL_W + CNT_W;
  localparam logic [LVL_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MULD,
    S_CHK,
    S_MULN,
    S_DIV,
    S_WB,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_index;
    logic [6:0] note_number;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  slot_number;
    logic [2:0]  envelope_phase;
    logic [15:0] envelope_level;
    logic [1:0]  status;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== src/padsr_div.sv =====
// padsr_div: restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on padsr_pkg; the caller guarantees num < den * 2**16 and den != 0.
`default_nettype none
module padsr_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [padsr_pkg::NUM_W-1:0]  num,
  input  wire logic [padsr_pkg::CNT_W-1:0]  den,
  output logic      [padsr_pkg::LVL_W-1:0]  quo,
  output padsr_pkg::div_stat_t              stat
);

  logic [padsr_pkg::CNT_W-1:0] rem_r, rem_nxt, den_r;
  logic [padsr_pkg::LVL_W-1:0] lo_r, lo_nxt;
  logic [4:0]                  cnt_r;
  logic                        run_r, done_r;
  logic [padsr_pkg::CNT_W:0]   trial, diff;
  logic                        ge;

  always_comb begin
    trial = {rem_r, lo_r[padsr_pkg::LVL_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[padsr_pkg::CNT_W-1:0] : trial[padsr_pkg::CNT_W-1:0];
    lo_nxt  = {lo_r[padsr_pkg::LVL_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[padsr_pkg::NUM_W-1:padsr_pkg::LVL_W];
      lo_r  <= num[padsr_pkg::LVL_W-1:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(padsr_pkg::LVL_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = lo_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== src/polyphonic_adsr_envelope_bank_core.sv =====
// polyphonic_adsr_envelope_bank_core: slot bank, sequencer, shared multiplier.
// Depends on padsr_pkg and padsr_div.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | padsr_pkg::in_beat_t
//  out_    | output    | out_valid / out_stall| padsr_pkg::out_beat_t
//  cfg     | input     | psel/penable/pready  | 32-bit registers at 4*i
//
// note on/off: the result goes straight to the emit step, then waits on the output.
// tick: the sequencer scans each slot; a busy slot on a ramp makes two passes through the shared 24x16
// multiplier, then waits on the serial divider that all slots share; a busy slot that holds sustain
// or ends its phase skips the divider.
// rst_n is synchronous; all slots go idle at once, no clearing pass.
// a stalled output holds the sequencer in its emit step; in_stall stays high
// until the last result of an item is in the output register.
`default_nettype none
module polyphonic_adsr_envelope_bank_core #(
  parameter int NUM_SLOTS      = padsr_pkg::NUM_SLOTS_DEF,
  parameter int SAMPLES_PER_MS = padsr_pkg::SAMPLES_PER_MS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire padsr_pkg::in_beat_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output padsr_pkg::out_beat_t      out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LW = padsr_pkg::LVL_W;
  localparam int CW = padsr_pkg::CNT_W;

  // configuration
  logic [LW-1:0] atk_r, dec_r, sus_r, rel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_r <= 16'd10;
      dec_r <= 16'd100;
      sus_r <= 16'd45875;
      rel_r <= 16'd200;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        padsr_pkg::REG_ATTACK:  atk_r <= pwdata[LW-1:0];
        padsr_pkg::REG_DECAY:   dec_r <= pwdata[LW-1:0];
        padsr_pkg::REG_SUSTAIN: sus_r <= pwdata[LW-1:0];
        padsr_pkg::REG_RELEASE: rel_r <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      padsr_pkg::REG_ATTACK:  prdata = 32'(atk_r);
      padsr_pkg::REG_DECAY:   prdata = 32'(dec_r);
      padsr_pkg::REG_SUSTAIN: prdata = 32'(sus_r);
      padsr_pkg::REG_RELEASE: prdata = 32'(rel_r);
      default:                prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // slot state
  padsr_pkg::phase_t phase_r [NUM_SLOTS];
  logic [LW-1:0]     level_r [NUM_SLOTS];
  logic [LW-1:0]     start_r [NUM_SLOTS];
  logic [CW-1:0]     count_r [NUM_SLOTS];
  logic [7:0]        key_r   [NUM_SLOTS];
  logic [6:0]        note_r  [NUM_SLOTS];

  padsr_pkg::seq_state_t state_r, state_nxt;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     c_r, d_r;
  padsr_pkg::phase_t nph_r;
  logic [LW-1:0]     nlvl_r;
  logic [CW-1:0]     ncnt_r;
  padsr_pkg::out_beat_t pend_r;
  logic              tick_r;
  logic              out_valid_r;
  padsr_pkg::out_beat_t out_data_r;

  logic [NUM_SLOTS-1:0] busy_vec, match_vec, later_vec;
  logic                 any_free, any_match, later_busy;
  logic [IW-1:0]        free_idx, match_idx;
  logic                 accept, out_free, emit_go, last_slot;
  logic [4:0]           idx_ext;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      busy_vec[s]  = phase_r[s] != padsr_pkg::PH_IDLE;
      match_vec[s] = busy_vec[s] && key_r[s] == in_data.key_index &&
                     note_r[s] == in_data.note_number;
    end
    any_free  = 1'b0;
    any_match = 1'b0;
    free_idx  = '0;
    match_idx = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (!busy_vec[s]) begin
        any_free = 1'b1;
        free_idx = IW'(s);
      end
      if (match_vec[s]) begin
        any_match = 1'b1;
        match_idx = IW'(s);
      end
    end
    later_vec  = (busy_vec >> idx_r) >> 1;
    later_busy = |later_vec;
    last_slot  = idx_r == IW'(NUM_SLOTS - 1);
    idx_ext    = 5'(idx_r);
  end

  // shared multiplier: span = ms * rate, then ramp numerator
  logic [CW-1:0]              mul_a;
  logic [LW-1:0]              mul_b, ms_sel;
  logic [padsr_pkg::NUM_W-1:0] mul_p;
  logic                       terminal;

  always_comb begin
    case (phase_r[idx_r])
      padsr_pkg::PH_ATTACK:  ms_sel = atk_r;
      padsr_pkg::PH_DECAY:   ms_sel = dec_r;
      padsr_pkg::PH_RELEASE: ms_sel = rel_r;
      default:               ms_sel = '0;
    endcase
    if (state_r == padsr_pkg::S_MULD) begin
      mul_a = CW'(ms_sel);
      mul_b = LW'(SAMPLES_PER_MS);
    end else begin
      case (phase_r[idx_r])
        padsr_pkg::PH_ATTACK: begin
          mul_a = c_r;
          mul_b = padsr_pkg::FULL_SCALE;
        end
        padsr_pkg::PH_DECAY: begin
          mul_a = c_r;
          mul_b = padsr_pkg::FULL_SCALE - sus_r;
        end
        default: begin
          mul_a = d_r - c_r;
          mul_b = start_r[idx_r];
        end
      endcase
    end
    mul_p    = padsr_pkg::NUM_W'(mul_a) * padsr_pkg::NUM_W'(mul_b);
    terminal = d_r == '0 || c_r >= d_r;
  end

  logic [LW-1:0]        quo;
  padsr_pkg::div_stat_t div_stat;
  logic                 div_start;

  padsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_p),
    .den   (d_r),
    .quo   (quo),
    .stat  (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      padsr_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == padsr_pkg::OP_TICK)
            state_nxt = padsr_pkg::S_SCAN;
          else if (in_data.opcode != padsr_pkg::OP_UNUSED)
            state_nxt = padsr_pkg::S_EMIT;
        end
      end
      padsr_pkg::S_SCAN: begin
        if (busy_vec[idx_r])   state_nxt = padsr_pkg::S_MULD;
        else if (last_slot)    state_nxt = padsr_pkg::S_IDLE;
      end
      padsr_pkg::S_MULD: state_nxt = padsr_pkg::S_CHK;
      padsr_pkg::S_CHK: begin
        if ((phase_r[idx_r] == padsr_pkg::PH_ATTACK ||
             phase_r[idx_r] == padsr_pkg::PH_DECAY ||
             phase_r[idx_r] == padsr_pkg::PH_RELEASE) && !terminal)
          state_nxt = padsr_pkg::S_MULN;
        else
          state_nxt = padsr_pkg::S_WB;
      end
      padsr_pkg::S_MULN: state_nxt = padsr_pkg::S_DIV;
      padsr_pkg::S_DIV:  if (div_stat.done) state_nxt = padsr_pkg::S_WB;
      padsr_pkg::S_WB:   state_nxt = padsr_pkg::S_EMIT;
      padsr_pkg::S_EMIT: begin
        if (out_free) begin
          if (!tick_r || last_slot) state_nxt = padsr_pkg::S_IDLE;
          else                      state_nxt = padsr_pkg::S_SCAN;
        end
      end
      default: state_nxt = padsr_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = state_r != padsr_pkg::S_IDLE;
    accept    = in_valid && state_r == padsr_pkg::S_IDLE;
    div_start = state_r == padsr_pkg::S_MULN;
    emit_go   = state_r == padsr_pkg::S_EMIT && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= padsr_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      tick_r <= 1'b0;
    end else begin
      if (accept) begin
        idx_r  <= '0;
        tick_r <= in_data.opcode == padsr_pkg::OP_TICK;
      end else if ((state_r == padsr_pkg::S_SCAN && !busy_vec[idx_r] && !last_slot) ||
                   (emit_go && tick_r && !last_slot)) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      padsr_pkg::S_SCAN: c_r <= count_r[idx_r] + CW'(1);
      padsr_pkg::S_MULD: d_r <= mul_p[CW-1:0];
      padsr_pkg::S_CHK: begin
        // a ramp that goes on keeps its count, the divider fills phase and level
        case (phase_r[idx_r])
          padsr_pkg::PH_ATTACK: begin
            nph_r  <= padsr_pkg::PH_DECAY;
            nlvl_r <= padsr_pkg::FULL_SCALE;
            ncnt_r <= terminal ? '0 : c_r;
          end
          padsr_pkg::PH_DECAY: begin
            nph_r  <= padsr_pkg::PH_SUSTAIN;
            nlvl_r <= sus_r;
            ncnt_r <= terminal ? '0 : c_r;
          end
          padsr_pkg::PH_SUSTAIN: begin
            nph_r  <= padsr_pkg::PH_SUSTAIN;
            nlvl_r <= sus_r;
            ncnt_r <= c_r;
          end
          default: begin
            nph_r  <= padsr_pkg::PH_IDLE;
            nlvl_r <= '0;
            ncnt_r <= c_r;
          end
        endcase
      end
      padsr_pkg::S_DIV: begin
        if (div_stat.done) begin
          case (phase_r[idx_r])
            padsr_pkg::PH_ATTACK: begin
              nph_r  <= padsr_pkg::PH_ATTACK;
              nlvl_r <= quo;
            end
            padsr_pkg::PH_DECAY: begin
              nph_r  <= padsr_pkg::PH_DECAY;
              nlvl_r <= padsr_pkg::FULL_SCALE - quo;
            end
            default: begin
              nph_r  <= (quo == '0) ? padsr_pkg::PH_IDLE : padsr_pkg::PH_RELEASE;
              nlvl_r <= quo;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r.last <= 1'b1;
      if (in_data.opcode == padsr_pkg::OP_NOTE_ON) begin
        pend_r.slot_number    <= any_free ? 3'(5'(free_idx)) : 3'd0;
        pend_r.envelope_phase <= any_free ? padsr_pkg::PH_ATTACK : padsr_pkg::PH_IDLE;
        pend_r.envelope_level <= '0;
        pend_r.status         <= any_free ? padsr_pkg::ST_OK : padsr_pkg::ST_NO_SLOT;
      end else begin
        pend_r.slot_number    <= any_match ? 3'(5'(match_idx)) : 3'd0;
        pend_r.envelope_phase <= any_match ? padsr_pkg::PH_RELEASE : padsr_pkg::PH_IDLE;
        pend_r.envelope_level <= any_match ? level_r[match_idx] : '0;
        pend_r.status         <= any_match ? padsr_pkg::ST_OK : padsr_pkg::ST_NO_MATCH;
      end
    end else if (state_r == padsr_pkg::S_WB) begin
      pend_r.slot_number    <= idx_ext[2:0];
      pend_r.envelope_phase <= nph_r;
      pend_r.envelope_level <= nlvl_r;
      pend_r.status         <= padsr_pkg::ST_OK;
      pend_r.last           <= !later_busy;
    end
  end

  // slot arrays
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        phase_r[s] <= padsr_pkg::PH_IDLE;
        level_r[s] <= '0;
        start_r[s] <= '0;
        count_r[s] <= '0;
      end
    end else if (accept && in_data.opcode == padsr_pkg::OP_NOTE_ON && any_free) begin
      phase_r[free_idx] <= padsr_pkg::PH_ATTACK;
      level_r[free_idx] <= '0;
      start_r[free_idx] <= '0;
      count_r[free_idx] <= '0;
    end else if (accept && in_data.opcode == padsr_pkg::OP_NOTE_OFF && any_match) begin
      phase_r[match_idx] <= padsr_pkg::PH_RELEASE;
      start_r[match_idx] <= level_r[match_idx];
      count_r[match_idx] <= '0;
    end else if (state_r == padsr_pkg::S_WB) begin
      phase_r[idx_r] <= nph_r;
      level_r[idx_r] <= nlvl_r;
      count_r[idx_r] <= ncnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == padsr_pkg::OP_NOTE_ON && any_free) begin
      key_r[free_idx]  <= in_data.key_index;
      note_r[free_idx] <= in_data.note_number;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) out_data_r <= pend_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == padsr_pkg::S_DIV)
    else $error("divider finished outside its step");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> d_r != '0)
    else $error("division started with zero span");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit_go)
    else $error("result overwritten while held");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for polyphonic_adsr_envelope_bank_core, with an
// in-file envelope predictor, random idle/stall on both channels and apb setup.
// Depends on padsr_pkg and the core RTL.
`default_nettype none
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  padsr_pkg::in_beat_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  padsr_pkg::out_beat_t out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  polyphonic_adsr_envelope_bank_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // predicted envelope bank
  logic [15:0] atk_ms, dec_ms, sus_lvl, rel_ms;
  padsr_pkg::phase_t env_phase [8];
  logic [15:0] env_level [8];
  logic [15:0] rel_from  [8];
  logic [23:0] env_count [8];
  logic [7:0]  env_key   [8];
  logic [6:0]  env_note  [8];

  padsr_pkg::out_beat_t report_q[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 19);
  endfunction

  function automatic void push_report(int s, padsr_pkg::phase_t ph, logic [15:0] lvl,
                                      logic [1:0] st, bit lst);
    padsr_pkg::out_beat_t r;
    r.slot_number = s[2:0];
    r.envelope_phase = ph;
    r.envelope_level = lvl;
    r.status = st;
    r.last = lst;
    report_q.push_back(r);
  endfunction

  function automatic void advance_slot(int s);
    longint unsigned d, c;
    env_count[s] = env_count[s] + 24'd1;
    c = env_count[s];
    case (env_phase[s])
      padsr_pkg::PH_ATTACK: begin
        d = atk_ms * 48;
        if (d == 0 || c >= d) begin
          env_level[s] = padsr_pkg::FULL_SCALE;
          env_phase[s] = padsr_pkg::PH_DECAY;
          env_count[s] = '0;
        end else begin
          env_level[s] = 16'((c * 65535) / d);
        end
      end
      padsr_pkg::PH_DECAY: begin
        d = dec_ms * 48;
        if (d == 0 || c >= d) begin
          env_level[s] = sus_lvl;
          env_phase[s] = padsr_pkg::PH_SUSTAIN;
          env_count[s] = '0;
        end else begin
          env_level[s] = 16'(65535 - (c * (65535 - longint'(sus_lvl))) / d);
        end
      end
      padsr_pkg::PH_SUSTAIN: env_level[s] = sus_lvl;
      padsr_pkg::PH_RELEASE: begin
        d = rel_ms * 48;
        if (d == 0 || c >= d) begin
          env_level[s] = '0;
          env_phase[s] = padsr_pkg::PH_IDLE;
        end else begin
          env_level[s] = 16'((longint'(rel_from[s]) * (d - c)) / d);
          if (env_level[s] == 0) env_phase[s] = padsr_pkg::PH_IDLE;
        end
      end
      default: begin
        env_level[s] = '0;
        env_phase[s] = padsr_pkg::PH_IDLE;
      end
    endcase
  endfunction

  function automatic void predict_envelopes(padsr_pkg::in_beat_t b);
    int n;
    int hit;
    n = 0;
    hit = -1;
    case (padsr_pkg::op_t'(b.opcode))
      padsr_pkg::OP_NOTE_ON: begin
        for (int s = 0; s < 8; s++)
          if (hit < 0 && env_phase[s] == padsr_pkg::PH_IDLE) hit = s;
        if (hit < 0) begin
          push_report(0, padsr_pkg::PH_IDLE, '0, padsr_pkg::ST_NO_SLOT, 1'b1);
        end else begin
          env_key[hit] = b.key_index;
          env_note[hit] = b.note_number;
          env_phase[hit] = padsr_pkg::PH_ATTACK;
          env_level[hit] = '0;
          rel_from[hit] = '0;
          env_count[hit] = '0;
          push_report(hit, padsr_pkg::PH_ATTACK, '0, padsr_pkg::ST_OK, 1'b1);
        end
      end
      padsr_pkg::OP_NOTE_OFF: begin
        for (int s = 0; s < 8; s++)
          if (hit < 0 && env_phase[s] != padsr_pkg::PH_IDLE &&
              env_key[s] == b.key_index && env_note[s] == b.note_number) hit = s;
        if (hit < 0) begin
          push_report(0, padsr_pkg::PH_IDLE, '0, padsr_pkg::ST_NO_MATCH, 1'b1);
        end else begin
          rel_from[hit] = env_level[hit];
          env_phase[hit] = padsr_pkg::PH_RELEASE;
          env_count[hit] = '0;
          push_report(hit, padsr_pkg::PH_RELEASE, env_level[hit], padsr_pkg::ST_OK, 1'b1);
        end
      end
      padsr_pkg::OP_TICK: begin
        for (int s = 0; s < 8; s++) begin
          if (env_phase[s] != padsr_pkg::PH_IDLE) begin
            advance_slot(s);
            push_report(s, env_phase[s], env_level[s], padsr_pkg::ST_OK, 1'b0);
            n++;
          end
        end
        if (n > 0) report_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(logic [1:0] op, logic [7:0] key, logic [6:0] note);
    padsr_pkg::in_beat_t b;
    b.opcode = op;
    b.key_index = key;
    b.note_number = note;
    if (idle_now()) begin
      in_valid <= 1'b0;
      while (idle_now() || $urandom_range(1) == 0) @(posedge clk);
    end
    predict_envelopes(b);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // drains the result queue with the input side quiet, then lets the core settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom_range(65535)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      padsr_pkg::REG_ATTACK:  atk_ms = val;
      padsr_pkg::REG_DECAY:   dec_ms = val;
      padsr_pkg::REG_SUSTAIN: sus_lvl = val;
      default:                rel_ms = val;
    endcase
  endtask

  task automatic set_envelope(logic [15:0] a, logic [15:0] d, logic [15:0] s,
                              logic [15:0] r);
    wait_quiet();
    write_reg(padsr_pkg::REG_ATTACK, a);
    write_reg(padsr_pkg::REG_DECAY, d);
    write_reg(padsr_pkg::REG_SUSTAIN, s);
    write_reg(padsr_pkg::REG_RELEASE, r);
  endtask

  task automatic release_all();
    for (int s = 0; s < 8; s++)
      if (env_phase[s] != padsr_pkg::PH_IDLE)
        send_beat(padsr_pkg::OP_NOTE_OFF, env_key[s], env_note[s]);
  endtask

  // allocation, drop when full, misses, re-release and the unused opcode
  task automatic test_slot_allocation();
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_NOTE_OFF, 8'h12, 7'h34);
    send_beat(padsr_pkg::OP_NOTE_ON, 8'hff, 7'h7f);
    send_beat(padsr_pkg::OP_NOTE_ON, 8'h00, 7'h00);
    for (int i = 0; i < 7; i++)
      send_beat(padsr_pkg::OP_NOTE_ON, 8'($urandom_range(255)), 7'($urandom_range(127)));
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_NOTE_OFF, 8'hff, 7'h7e);
    send_beat(padsr_pkg::OP_NOTE_OFF, 8'hff, 7'h7f);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_NOTE_OFF, 8'hff, 7'h7f);
    send_beat(padsr_pkg::OP_UNUSED, 8'haa, 7'h55);
    send_beat(padsr_pkg::OP_NOTE_ON, 8'h5a, 7'h2a);
  endtask

  // zero lengths jump through attack and decay, zero release silences at once
  task automatic test_zero_lengths();
    set_envelope(16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    release_all();
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_UNUSED, 8'h00, 7'h00);
  endtask

  // full-scale registers, then shortened durations end running phases
  task automatic test_register_extremes();
    set_envelope(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_beat(padsr_pkg::OP_NOTE_ON, 8'h01, 7'h01);
    send_beat(padsr_pkg::OP_NOTE_ON, 8'h80, 7'h40);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_NOTE_OFF, 8'h80, 7'h40);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    set_envelope(16'd0, 16'hffff, 16'hffff, 16'd0);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
    release_all();
    send_beat(padsr_pkg::OP_TICK, 8'h00, 7'h00);
  endtask

  task automatic test_random_notes(int count, logic [15:0] a, logic [15:0] d,
                                   logic [15:0] s, logic [15:0] r);
    int pick;
    int busy[$];
    set_envelope(a, d, s, r);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      busy = {};
      for (int k = 0; k < 8; k++)
        if (env_phase[k] != padsr_pkg::PH_IDLE) busy.push_back(k);
      if (pick < 22) begin
        send_beat(padsr_pkg::OP_NOTE_ON, 8'($urandom_range(255)),
                  7'($urandom_range(127)));
      end else if (pick < 34) begin
        if (busy.size() != 0 && $urandom_range(4) != 0) begin
          pick = busy[$urandom_range(busy.size() - 1)];
          send_beat(padsr_pkg::OP_NOTE_OFF, env_key[pick], env_note[pick]);
        end else begin
          send_beat(padsr_pkg::OP_NOTE_OFF, 8'($urandom_range(255)),
                    7'($urandom_range(127)));
        end
      end else if (pick < 97) begin
        send_beat(padsr_pkg::OP_TICK, 8'($urandom_range(255)), 7'($urandom_range(127)));
      end else begin
        send_beat(padsr_pkg::OP_UNUSED, 8'($urandom_range(255)),
                  7'($urandom_range(127)));
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    padsr_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: slot %0d phase %0d level %0d status %0d last %0d",
                   out_data.slot_number, out_data.envelope_phase,
                   out_data.envelope_level, out_data.status, out_data.last);
      end else begin
        want = report_q.pop_front();
        if (out_data.slot_number !== want.slot_number ||
            out_data.envelope_phase !== want.envelope_phase ||
            out_data.envelope_level !== want.envelope_level ||
            out_data.status !== want.status || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected slot %0d phase %0d level %0d status %0d last %0d",
                     want.slot_number, want.envelope_phase, want.envelope_level,
                     want.status, want.last);
            $display("                 got      slot %0d phase %0d level %0d status %0d last %0d",
                     out_data.slot_number, out_data.envelope_phase,
                     out_data.envelope_level, out_data.status, out_data.last);
          end
        end
      end
    end
    out_stall <= idle_now();
  end

  initial begin
    atk_ms = 16'd10;
    dec_ms = 16'd100;
    sus_lvl = 16'd45875;
    rel_ms = 16'd200;
    for (int s = 0; s < 8; s++) begin
      env_phase[s] = padsr_pkg::PH_IDLE;
      env_level[s] = '0;
      rel_from[s] = '0;
      env_count[s] = '0;
      env_key[s] = '0;
      env_note[s] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_slot_allocation();
    test_zero_lengths();
    test_register_extremes();
    test_random_notes(40, 16'd1, 16'd1, 16'($urandom_range(65535)), 16'd1);
    calm = 1'b1;
    test_random_notes(35, 16'd0, 16'd2, 16'd0, 16'd0);
    calm = 1'b0;
    test_random_notes(35, 16'd2, 16'd0, 16'hffff, 16'd1);
    test_random_notes(30, 16'd1, 16'd1, 16'($urandom_range(65535)), 16'd0);
    wait_quiet();
    if (mismatches == 0) begin
      $display("polyphonic_adsr_envelope_bank_core verification clean");
    end else begin
      $display("polyphonic_adsr_envelope_bank_core verification failed");
    end
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("polyphonic_adsr_envelope_bank_core verification failed");
    $finish;
  end

endmodule
`default_nettype wire
